FILE: rtl/utf16_to_utf8_transcoder_macros.svh
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder assertion macros
// Shared concurrent assertion forms for the transcoder checker.
// ----------------------------------------------------------------------------
`ifndef UTF16_TO_UTF8_TRANSCODER_MACROS_SVH
`define UTF16_TO_UTF8_TRANSCODER_MACROS_SVH

// Check a property on every rising edge outside reset.
`define UTT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("utt assertion failed");

// Check that an antecedent implies a consequent in the same cycle.
`define UTT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  `UTT_ASSERT(lbl, clk, rst_n, (ante) |-> (cons))

// Check that an antecedent implies a consequent in the next cycle.
`define UTT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  `UTT_ASSERT(lbl, clk, rst_n, (ante) |=> (cons))

`endif

FILE: rtl/utt_pkg.sv
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder package
// Shared constants, byte job type and the scalar encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package utt_pkg;

  localparam logic [15:0] HiSurrFirst = 16'hD800;
  localparam logic [15:0] HiSurrLast  = 16'hDBFF;
  localparam logic [15:0] LoSurrFirst = 16'hDC00;
  localparam logic [15:0] LoSurrLast  = 16'hDFFF;
  localparam logic [20:0] SuppBase    = 21'h10000;
  localparam logic [7:0]  ContMark    = 8'h80;
  localparam logic [7:0]  Lead2Mark   = 8'hC0;
  localparam logic [7:0]  Lead3Mark   = 8'hE0;
  localparam logic [7:0]  Lead4Mark   = 8'hF0;
  localparam logic [7:0]  SixBits     = 8'h3F;

  localparam int MaxBytes   = 6;
  localparam int CntW       = 3;
  localparam int QueueDepth = 2;
  localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW      = $clog2(QueueDepth + 1);

  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [CntW-1:0]          cnt;
    logic                     fin;
  } job_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [CntW-1:0] len;
  } enc_t;

  function automatic enc_t encode_scalar(input logic [20:0] sc);
    enc_t e;
    e.bytes = '0;
    if (sc < 21'h80) begin
      e.bytes[0] = sc[7:0];
      e.len      = 3'd1;
    end else if (sc < 21'h800) begin
      e.bytes[0] = Lead2Mark | {3'b000, sc[10:6]};
      e.bytes[1] = ContMark | ({2'b00, sc[5:0]} & SixBits);
      e.len      = 3'd2;
    end else if (sc < SuppBase) begin
      e.bytes[0] = Lead3Mark | {4'b0000, sc[15:12]};
      e.bytes[1] = ContMark | ({2'b00, sc[11:6]} & SixBits);
      e.bytes[2] = ContMark | ({2'b00, sc[5:0]} & SixBits);
      e.len      = 3'd3;
    end else begin
      e.bytes[0] = Lead4Mark | {5'b00000, sc[20:18]};
      e.bytes[1] = ContMark | ({2'b00, sc[17:12]} & SixBits);
      e.bytes[2] = ContMark | ({2'b00, sc[11:6]} & SixBits);
      e.bytes[3] = ContMark | ({2'b00, sc[5:0]} & SixBits);
      e.len      = 3'd4;
    end
    return e;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/utt_fifo.sv
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder job queue
// Short first-in first-out queue of byte jobs between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module utt_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  utt_pkg::job_t wdata_i,
  input  logic          rd_i,
  output utt_pkg::job_t rdata_o,
  output logic          full_o,
  output logic          empty_o
);
  import utt_pkg::*;

  job_t             mem_q [QueueDepth];
  logic [QPtrW-1:0] wptr_q, wptr_d;
  logic [QPtrW-1:0] rptr_q, rptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == QCntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_wr) begin
      wptr_d = (wptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_rd) begin
      rptr_d = (rptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/utt_front.sv
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder front end
// Accepts code units, pairs surrogates, builds at most one byte job per unit.
// ----------------------------------------------------------------------------
`default_nettype none

module utt_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [15:0]   code_unit_i,
  input  logic          last_unit_i,
  input  logic          q_full_i,
  output logic          q_wr_o,
  output utt_pkg::job_t job_o
);
  import utt_pkg::*;

  logic       pend_valid_q, pend_valid_d;
  logic [9:0] pend_bits_q, pend_bits_d;
  logic       accept, is_high, is_low, hold, job_valid;
  enc_t       pair_e, flush_e, main_e;

  assign accept  = push_i && !q_full_i;
  assign is_high = code_unit_i inside {[HiSurrFirst:HiSurrLast]};
  assign is_low  = code_unit_i inside {[LoSurrFirst:LoSurrLast]};
  assign hold    = is_high && !last_unit_i;

  assign pair_e  = encode_scalar(SuppBase + {1'b0, pend_bits_q, code_unit_i[9:0]});
  assign flush_e = encode_scalar({5'd0, HiSurrFirst[15:10], pend_bits_q});
  assign main_e  = encode_scalar({5'd0, code_unit_i});

  always_comb begin
    job_o.bytes = '0;
    job_o.cnt   = '0;
    job_o.fin   = last_unit_i;
    job_valid   = 1'b0;
    if (pend_valid_q && is_low) begin
      job_o.bytes[3:0] = pair_e.bytes;
      job_o.cnt        = pair_e.len;
      job_valid        = 1'b1;
    end else if (pend_valid_q) begin
      job_o.bytes[2:0] = flush_e.bytes[2:0];
      job_o.cnt        = 3'd3;
      job_valid        = 1'b1;
      if (!hold) begin
        job_o.bytes[5:3] = main_e.bytes[2:0];
        job_o.cnt        = 3'd3 + main_e.len;
      end
    end else if (!hold) begin
      job_o.bytes[3:0] = main_e.bytes;
      job_o.cnt        = main_e.len;
      job_valid        = 1'b1;
    end
  end

  assign q_wr_o = accept && job_valid;

  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_bits_d  = pend_bits_q;
    if (accept) begin
      pend_valid_d = hold;
      pend_bits_d  = hold ? code_unit_i[9:0] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      pend_bits_q  <= '0;
    end else begin
      pend_valid_q <= pend_valid_d;
      pend_bits_q  <= pend_bits_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/utt_back.sv
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder back end
// Takes byte jobs from the queue and hands out one byte per request.
// ----------------------------------------------------------------------------
`default_nettype none

module utt_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  input  utt_pkg::job_t q_rdata_i,
  output logic          q_rd_o,
  input  logic          pop_i,
  output logic          empty_o,
  output logic [7:0]    out_byte_o,
  output logic          run_last_o,
  output logic          string_end_o
);
  import utt_pkg::*;

  job_t            cur_q;
  logic            cur_valid_q;
  logic [CntW-1:0] idx_q;
  logic            last_byte, take, load, advance;

  assign last_byte = (idx_q == cur_q.cnt - 1'b1);
  assign advance   = pop_i && cur_valid_q;
  assign take      = !cur_valid_q || (advance && last_byte);
  assign load      = take && !q_empty_i;
  assign q_rd_o    = load;

  assign empty_o      = !cur_valid_q;
  assign out_byte_o   = cur_q.bytes[idx_q];
  assign run_last_o   = last_byte;
  assign string_end_o = last_byte && cur_q.fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (load) begin
      cur_valid_q <= 1'b1;
      idx_q       <= '0;
    end else if (advance && last_byte) begin
      cur_valid_q <= 1'b0;
    end else if (advance) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= q_rdata_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/utf16_to_utf8_transcoder.sv
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder
// Converts a stream of UTF-16 code units into UTF-8 bytes.
// ----------------------------------------------------------------------------
// A code unit is taken in every cycle while full is low; the result side
// hands out one byte per cycle while pop is high, so a unit that yields n
// bytes takes n pops to drain (ASCII: one unit per cycle end to end). A
// high surrogate that is not a string's last unit waits for the next unit
// and yields no bytes on its own; lone surrogates come out as 3-byte
// sequences, so one unit can yield up to 6 bytes. The byte serializer in
// the back end sets the output rate, and a two-entry job queue lets the
// front end keep accepting units while bytes of earlier units still drain.
`default_nettype none

module utf16_to_utf8_transcoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [15:0] code_unit_i,
  input  logic        last_unit_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic        run_last_o,
  output logic        string_end_o
);
  import utt_pkg::*;

  job_t wjob, rjob;
  logic q_wr, q_rd, q_full, q_empty;

  assign full = q_full;

  utt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .code_unit_i (code_unit_i),
    .last_unit_i (last_unit_i),
    .q_full_i    (q_full),
    .q_wr_o      (q_wr),
    .job_o       (wjob)
  );

  utt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .wdata_i (wjob),
    .rd_i    (q_rd),
    .rdata_o (rjob),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  utt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_rdata_i    (rjob),
    .q_rd_o       (q_rd),
    .pop_i        (pop),
    .empty_o      (empty),
    .out_byte_o   (out_byte_o),
    .run_last_o   (run_last_o),
    .string_end_o (string_end_o)
  );

endmodule

`default_nettype wire

FILE: rtl/utt_checker.sv
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder checker
// Port-level assertions on the result side, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "utf16_to_utf8_transcoder_macros.svh"

module utt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte_o,
  input logic       run_last_o,
  input logic       string_end_o
);

  `UTT_ASSERT_NEXT(a_result_holds, clk_i, rst_ni, !empty && !pop, !empty)
  `UTT_ASSERT_NEXT(a_byte_stable, clk_i, rst_ni, !empty && !pop, $stable(out_byte_o))
  `UTT_ASSERT_SAME(a_end_is_run_last, clk_i, rst_ni, !empty && string_end_o, run_last_o)
  `UTT_ASSERT_SAME(a_lead_not_last, clk_i, rst_ni, !empty && out_byte_o[7:6] == 2'b11,
                   !run_last_o)
  `UTT_ASSERT_SAME(a_ascii_is_last, clk_i, rst_ni, !empty && !out_byte_o[7], run_last_o)

endmodule

bind utf16_to_utf8_transcoder utt_checker u_checker (.*);

`default_nettype wire

FILE: bench/utf16_to_utf8_transcoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder testbench
// Streams UTF-16 strings into the transcoder and checks every UTF-8 byte,
// with its run and string flags, against a cycle-free model of the encoding
// that tracks the held high surrogate. Directed corner units come first,
// then random strings of mixed scalars, surrogate pairs and lone surrogates
// under changing request gaps and back pressure.
// ----------------------------------------------------------------------------

module utf16_to_utf8_transcoder_test;
  import utt_pkg::*;

  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned MaxShown    = 10;
  localparam int unsigned DrainCycles = 20;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       string_end;
  } utf8_byte_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        push         = 1'b0;
  logic        full;
  logic [15:0] code_unit_i  = '0;
  logic        last_unit_i  = 1'b0;
  logic        empty;
  logic        pop          = 1'b0;
  logic [7:0]  out_byte_o;
  logic        run_last_o;
  logic        string_end_o;

  utf8_byte_t  utf8_due[$];
  logic [7:0]  unit_bytes[$];
  logic        held_valid = 1'b0;
  logic [9:0]  held_bits  = '0;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned fail_count  = 0;
  int unsigned stall_count = 0;

  utf16_to_utf8_transcoder u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .code_unit_i  (code_unit_i),
    .last_unit_i  (last_unit_i),
    .empty        (empty),
    .pop          (pop),
    .out_byte_o   (out_byte_o),
    .run_last_o   (run_last_o),
    .string_end_o (string_end_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= MaxShown) begin
      $display("%0t: %s", $realtime, msg);
    end
  endtask

  function automatic void add_unit_byte(input logic [7:0] v);
    unit_bytes.insert(unit_bytes.size(), v);
  endfunction

  function automatic void put_utf8(input logic [20:0] sc);
    if (sc < 21'h80) begin
      add_unit_byte(sc[7:0]);
    end else if (sc < 21'h800) begin
      add_unit_byte(Lead2Mark | {3'b000, sc[10:6]});
      add_unit_byte(ContMark | {2'b00, sc[5:0]});
    end else if (sc < SuppBase) begin
      add_unit_byte(Lead3Mark | {4'b0000, sc[15:12]});
      add_unit_byte(ContMark | {2'b00, sc[11:6]});
      add_unit_byte(ContMark | {2'b00, sc[5:0]});
    end else begin
      add_unit_byte(Lead4Mark | {5'b00000, sc[20:18]});
      add_unit_byte(ContMark | {2'b00, sc[17:12]});
      add_unit_byte(ContMark | {2'b00, sc[11:6]});
      add_unit_byte(ContMark | {2'b00, sc[5:0]});
    end
  endfunction

  function automatic void transcode_unit(input logic [15:0] unit, input logic fin);
    logic       is_high;
    logic       is_low;
    logic       paired;
    utf8_byte_t b;
    is_high = unit >= HiSurrFirst && unit <= HiSurrLast;
    is_low  = unit >= LoSurrFirst && unit <= LoSurrLast;
    paired  = 1'b0;
    unit_bytes.delete();
    if (held_valid) begin
      held_valid = 1'b0;
      if (is_low) begin
        put_utf8(SuppBase + {1'b0, held_bits, unit[9:0]});
        paired = 1'b1;
      end else begin
        put_utf8({5'b00000, HiSurrFirst | {6'b000000, held_bits}});
      end
      held_bits = '0;
    end
    if (!paired) begin
      if (is_high && !fin) begin
        held_valid = 1'b1;
        held_bits  = unit[9:0];
      end else begin
        put_utf8({5'b00000, unit});
      end
    end
    foreach (unit_bytes[k]) begin
      b.data       = unit_bytes[k];
      b.run_last   = (k == unit_bytes.size() - 1);
      b.string_end = b.run_last && fin;
      utf8_due.insert(utf8_due.size(), b);
    end
  endfunction

  task automatic send_unit(input logic [15:0] unit, input logic fin);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    push        <= 1'b1;
    code_unit_i <= unit;
    last_unit_i <= fin;
    do @(posedge clk_i); while (full);
    transcode_unit(unit, fin);
  endtask

  task automatic hold_until_drained();
    push <= 1'b0;
    do @(posedge clk_i); while (utf8_due.size() != 0);
  endtask

  always @(posedge clk_i) begin
    pop <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    utf8_byte_t want;
    if (rst_ni && pop && !empty) begin
      if (utf8_due.size() == 0) begin
        note_failure($sformatf("unexpected byte %h run_last %b string_end %b",
                               out_byte_o, run_last_o, string_end_o));
      end else begin
        want = utf8_due.pop_front();
        if (out_byte_o !== want.data || run_last_o !== want.run_last ||
            string_end_o !== want.string_end) begin
          note_failure($sformatf(
            "byte mismatch: expected %h/%b/%b, got %h/%b/%b",
            want.data, want.run_last, want.string_end,
            out_byte_o, run_last_o, string_end_o));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) begin
        stall_count <= 0;
      end else if (stall_count >= StallLimit) begin
        $display("utf16_to_utf8_transcoder_test failed");
        $finish;
      end else begin
        stall_count <= stall_count + 1;
      end
    end
  end

  task automatic test_directed_units();
    send_unit(16'h0000, 1'b0);
    send_unit(16'h007F, 1'b0);
    send_unit(16'h0080, 1'b0);
    send_unit(16'h07FF, 1'b0);
    send_unit(16'h0800, 1'b0);
    send_unit(16'hD7FF, 1'b0);
    send_unit(16'hE000, 1'b0);
    send_unit(16'hFFFF, 1'b1);
    send_unit(HiSurrFirst, 1'b0);
    send_unit(LoSurrFirst, 1'b0);
    send_unit(HiSurrLast, 1'b0);
    send_unit(LoSurrLast, 1'b1);
    send_unit(LoSurrFirst, 1'b0);
    send_unit(LoSurrLast, 1'b1);
    send_unit(HiSurrFirst, 1'b0);
    send_unit(16'h0041, 1'b0);
    send_unit(HiSurrLast, 1'b0);
    send_unit(16'hD801, 1'b0);
    send_unit(16'hDC01, 1'b1);
    send_unit(16'hDA00, 1'b1);
    send_unit(16'hD900, 1'b0);
    send_unit(16'hDB00, 1'b1);
    send_unit(16'hD900, 1'b0);
    send_unit(16'hFFFF, 1'b1);
  endtask

  task automatic test_held_surrogate_across_pause();
    send_unit(16'hD834, 1'b0);
    hold_until_drained();
    send_unit(16'hDD1E, 1'b1);
    hold_until_drained();
  endtask

  task automatic test_random_strings(input int unsigned unit_budget);
    int unsigned sent;
    int unsigned kind;
    logic [15:0] units[$];
    logic [15:0] u;
    logic [15:0] v;
    sent = 0;
    while (sent < unit_budget) begin
      units.delete();
      repeat ($urandom_range(10, 1)) begin
        kind = $urandom_range(99);
        if (kind < 35) begin
          u = 16'($urandom_range(16'h007F, 16'h0000));
          units.insert(units.size(), u);
        end else if (kind < 50) begin
          u = 16'($urandom_range(16'h07FF, 16'h0080));
          units.insert(units.size(), u);
        end else if (kind < 65) begin
          u = 16'($urandom_range(16'hFFFF, 16'h0800));
          if (u >= HiSurrFirst && u <= LoSurrLast) begin
            u = u ^ 16'h2000;
          end
          units.insert(units.size(), u);
        end else if (kind < 85) begin
          u = 16'($urandom_range(HiSurrLast, HiSurrFirst));
          v = 16'($urandom_range(LoSurrLast, LoSurrFirst));
          units.insert(units.size(), u);
          units.insert(units.size(), v);
        end else if (kind < 90) begin
          u = 16'($urandom_range(LoSurrLast, LoSurrFirst));
          units.insert(units.size(), u);
        end else if (kind < 95) begin
          u = 16'($urandom_range(HiSurrLast, HiSurrFirst));
          units.insert(units.size(), u);
        end else begin
          u = 16'($urandom_range(16'hFFFF, 16'h0000));
          units.insert(units.size(), u);
        end
      end
      foreach (units[i]) begin
        send_unit(units[i], (i == units.size() - 1) || ($urandom_range(99) < 3));
      end
      sent += units.size();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 15;
    rx_idle_pct = 48;
    test_directed_units();
    test_held_surrogate_across_pause();
    test_random_strings(130);
    hold_until_drained();

    tx_idle_pct = 48;
    rx_idle_pct = 15;
    test_random_strings(130);
    hold_until_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_strings(140);

    hold_until_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (utf8_due.size() != 0) begin
      note_failure($sformatf("%0d bytes never arrived", utf8_due.size()));
    end
    if (fail_count == 0) begin
      $display("utf16_to_utf8_transcoder_test passed");
    end else begin
      $display("utf16_to_utf8_transcoder_test failed");
    end
    $finish;
  end

endmodule
